### rtl/trivariate_quadratic_bezier_eval_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triquadratic Bezier lattice block
// Concurrent check wrappers that share one clock and reset convention.
// ----------------------------------------------------------------------------
`ifndef TRIVARIATE_QUADRATIC_BEZIER_EVAL_ASSERT_SVH
`define TRIVARIATE_QUADRATIC_BEZIER_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TQBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tqbe: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TQBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tqbe: next-cycle check failed");

`endif

### rtl/tqbe_pkg.sv
// ----------------------------------------------------------------------------
// tqbe_pkg
// Shared constants and types of the triquadratic Bezier lattice block.
// ----------------------------------------------------------------------------
package tqbe_pkg;

    localparam int COORD_BITS = 24;
    localparam int NUM_POINTS = 27;
    localparam int IDX_BITS   = 5;
    localparam int PARAM_BITS = 17;
    localparam int MODE_BITS  = 2;
    localparam int LANES      = 3;

    // Multiplier operands hold a signed coordinate plus two bits of headroom.
    localparam int MUL_W  = COORD_BITS + 2;
    localparam int PROD_W = 2 * MUL_W;

    localparam int IN_DATA_W  = ((IDX_BITS + LANES * COORD_BITS + LANES * PARAM_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LANES * COORD_BITS + IDX_BITS + 7) / 8) * 8;

    localparam logic [PARAM_BITS-1:0] ONE_Q16 = PARAM_BITS'(65536);

    localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_EVAL  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_NEAR  = 2'd2;

    typedef enum logic [2:0] {
        OP_WGT   = 3'd0,
        OP_ROW   = 3'd1,
        OP_BW    = 3'd2,
        OP_COORD = 3'd3,
        OP_DIST  = 3'd4
    } t_op;

    typedef logic [LANES-1:0][COORD_BITS-1:0] t_point;

    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic [IDX_BITS-1:0] idx;
    } t_mul_tag;

    typedef struct packed {
        t_mul_tag                   tag;
        logic [LANES-1:0][MUL_W-1:0] a;
        logic [LANES-1:0][MUL_W-1:0] b;
    } t_mul_req;

endpackage

### rtl/trivariate_quadratic_bezier_eval.sv
// ----------------------------------------------------------------------------
// trivariate_quadratic_bezier_eval
// Triquadratic Bezier lattice: point store, volume evaluation, nearest query.
// ----------------------------------------------------------------------------
// The block holds a 3x3x3 lattice of control points (index 9*t + 3*u + s),
// selected by the mode in s_axis_tuser. A write (mode 0) gives no result;
// an index above 26 is dropped, as is mode 3. During an evaluation (mode 1)
// or a nearest-point query (mode 2) the input is not ready until the result
// is loaded into the output register. Both are paced by the one three-lane
// multiplier that is shared by the weight, row-weight, point-weight and
// coordinate products of the evaluation and by the squared distances of the
// query, and by the single read port of the lattice store, which yields one
// point a cycle. A finished result waits in an output register, so the next
// transaction is accepted while it is still pending. Control points must be
// written before any query reads them.
// ----------------------------------------------------------------------------
`include "trivariate_quadratic_bezier_eval_assert.svh"

module trivariate_quadratic_bezier_eval (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // point_index, coord_x, coord_y, coord_z, param_s, param_t, param_u
    input  logic [tqbe_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  logic [tqbe_pkg::MODE_BITS-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pos_x, pos_y, pos_z, nearest_index, zero fill
    output logic [tqbe_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int CB     = tqbe_pkg::COORD_BITS;
    localparam int PB     = tqbe_pkg::PARAM_BITS;
    localparam int LN     = tqbe_pkg::LANES;
    localparam int IB     = tqbe_pkg::IDX_BITS;
    localparam int MW     = tqbe_pkg::MUL_W;
    localparam int PW     = tqbe_pkg::PROD_W;
    localparam int ACC_W  = CB + PB + 5;
    localparam int DIFF_W = CB + 1;
    localparam int SQ_W   = 2 * CB + 1;
    localparam int DIST_W = 2 * CB + 2;
    localparam int SH_W   = ACC_W - 15;
    localparam int P_BASE = IB + LN * CB;

    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((64'sd1 <<< (CB - 1)) - 1);
    localparam logic signed [SH_W-1:0] SAT_MIN = -SAT_MAX - SH_W'(1);
    localparam logic [IB-1:0]          LAST_PT = IB'(tqbe_pkg::NUM_POINTS - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_WGT   = 9'b000000010,
        ST_WAIT  = 9'b000000100,
        ST_ROW   = 9'b000001000,
        ST_ROWW  = 9'b000010000,
        ST_BOP   = 9'b000100000,
        ST_COP   = 9'b001000000,
        ST_NEAR  = 9'b010000000,
        ST_DRAIN = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_a, n_a, r_b, n_b, r_c, n_c;
    logic [IB-1:0] r_pt, n_pt;

    logic                              r_near;
    logic [LN-1:0][PB-1:0]             r_p, r_q;
    tqbe_pkg::t_point                  r_qc;
    logic [LN-1:0][2:0][PB-1:0]        r_w;
    logic [2:0][PB-1:0]                r_wtu;
    logic [2:0][2:0][PB-1:0]           r_wpt;
    logic [LN-1:0][ACC_W-1:0]          r_acc;

    logic                              r_rdv;
    logic [IB-1:0]                     r_rd_idx;
    logic [LN-1:0][DIFF_W-1:0]         r_diff;
    logic                              r_dv;
    logic [IB-1:0]                     r_di;
    logic [DIST_W-1:0]                 r_dist;
    logic                              r_distv;
    logic [IB-1:0]                     r_disti;
    logic [DIST_W-1:0]                 r_best;
    logic [IB-1:0]                     r_bidx;

    logic                              r_ovld;
    tqbe_pkg::t_point                  r_opos;
    logic [IB-1:0]                     r_onidx;

    logic                              s_acc;
    logic [IB-1:0]                     in_idx;
    tqbe_pkg::t_point                  in_pt;
    logic [LN-1:0][PB-1:0]             in_p, in_q;
    logic                              wr_en;
    logic                              rd_en;
    logic [IB-1:0]                     rd_addr;
    tqbe_pkg::t_point                  rd_data;
    tqbe_pkg::t_mul_req                mul_req;
    logic [LN-1:0][PW-1:0]             mul_prod;
    tqbe_pkg::t_mul_tag                mul_tag;
    logic                              pipe_empty;
    logic                              out_load;
    logic [IB-1:0]                     pt_chk;

    // Round half up from Q.32 to Q.16.
    function automatic logic [PB-1:0] f_rnd(input logic [33:0] v);
        logic [34:0] s;
        s = {1'b0, v} + 35'd32768;
        return s[32:16];
    endfunction

    // Round to Q8.16 and saturate to the coordinate range.
    function automatic logic [CB-1:0] f_finish(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0]          s;
        logic signed [SH_W-1:0]  sh;
        s  = {acc[ACC_W-1], acc} + (ACC_W + 1)'(32768);
        sh = s[ACC_W:16];
        if (sh > SAT_MAX) begin
            return SAT_MAX[CB-1:0];
        end else if (sh < SAT_MIN) begin
            return SAT_MIN[CB-1:0];
        end
        return sh[CB-1:0];
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_idx = s_axis_tdata[IB-1:0];
        for (int k = 0; k < LN; k++) begin
            in_pt[k] = s_axis_tdata[IB + k*CB +: CB];
            in_p[k]  = s_axis_tdata[P_BASE + k*PB +: PB];
            if (in_p[k] > tqbe_pkg::ONE_Q16) begin
                in_p[k] = tqbe_pkg::ONE_Q16;
            end
            in_q[k] = tqbe_pkg::ONE_Q16 - in_p[k];
        end
    end

    assign wr_en = s_acc && (s_axis_tuser == tqbe_pkg::MODE_WRITE)
                   && (in_idx <= LAST_PT);

    // A coordinate read is issued in the cycle before the product that uses it.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_pt;
        case (r_state)
            ST_NEAR: begin
                rd_en = 1'b1;
            end
            ST_BOP: begin
                rd_en = (r_b == 2'd2);
            end
            ST_COP: begin
                rd_en   = (r_pt != LAST_PT);
                rd_addr = r_pt + IB'(1);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    tqbe_lattice u_lattice (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (in_idx),
        .i_wdata (in_pt),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_req = '0;
        if (r_dv) begin
            mul_req.tag.vld = 1'b1;
            mul_req.tag.op  = tqbe_pkg::OP_DIST;
            mul_req.tag.idx = r_di;
            for (int k = 0; k < LN; k++) begin
                mul_req.a[k] = MW'($signed(r_diff[k]));
                mul_req.b[k] = MW'($signed(r_diff[k]));
            end
        end else begin
            case (r_state)
                ST_WGT: begin
                    mul_req.tag.vld = 1'b1;
                    mul_req.tag.op  = tqbe_pkg::OP_WGT;
                    mul_req.tag.idx = IB'(r_c);
                    for (int k = 0; k < LN; k++) begin
                        mul_req.a[k] = (r_c == 2'd2) ? MW'(r_p[k]) : MW'(r_q[k]);
                        mul_req.b[k] = (r_c == 2'd0) ? MW'(r_q[k]) : MW'(r_p[k]);
                    end
                end
                ST_ROW: begin
                    mul_req.tag.vld = 1'b1;
                    mul_req.tag.op  = tqbe_pkg::OP_ROW;
                    for (int k = 0; k < LN; k++) begin
                        mul_req.a[k] = MW'(r_w[1][r_a]);
                        mul_req.b[k] = MW'(r_w[2][k]);
                    end
                end
                ST_BOP: begin
                    mul_req.tag.vld = 1'b1;
                    mul_req.tag.op  = tqbe_pkg::OP_BW;
                    mul_req.tag.idx = IB'(r_b);
                    for (int k = 0; k < LN; k++) begin
                        mul_req.a[k] = MW'(r_wtu[r_b]);
                        mul_req.b[k] = MW'(r_w[0][k]);
                    end
                end
                ST_COP: begin
                    mul_req.tag.vld = 1'b1;
                    mul_req.tag.op  = tqbe_pkg::OP_COORD;
                    mul_req.tag.idx = r_pt;
                    for (int k = 0; k < LN; k++) begin
                        mul_req.a[k] = MW'(r_wpt[r_b][r_c]);
                        mul_req.b[k] = MW'($signed(rd_data[k]));
                    end
                end
                default: begin
                    mul_req.tag.vld = 1'b0;
                end
            endcase
        end
    end

    tqbe_mul3 u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_prod  (mul_prod),
        .o_tag   (mul_tag)
    );

    assign pipe_empty = !r_rdv && !r_dv && !mul_tag.vld && !r_distv;
    assign out_load   = (r_state == ST_DRAIN) && pipe_empty
                        && (!r_ovld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_pt    = r_pt;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_a  = 2'd0;
                    n_b  = 2'd0;
                    n_c  = 2'd0;
                    n_pt = '0;
                    if (s_axis_tuser == tqbe_pkg::MODE_EVAL) begin
                        n_state = ST_WGT;
                    end else if (s_axis_tuser == tqbe_pkg::MODE_NEAR) begin
                        n_state = ST_NEAR;
                    end
                end
            end
            ST_WGT: begin
                if (r_c == 2'd2) begin
                    n_c     = 2'd0;
                    n_state = ST_WAIT;
                end else begin
                    n_c = r_c + 2'd1;
                end
            end
            ST_WAIT: begin
                n_state = ST_ROW;
            end
            ST_ROW: begin
                n_state = ST_ROWW;
            end
            ST_ROWW: begin
                n_b     = 2'd0;
                n_state = ST_BOP;
            end
            ST_BOP: begin
                if (r_b == 2'd2) begin
                    n_b     = 2'd0;
                    n_c     = 2'd0;
                    n_state = ST_COP;
                end else begin
                    n_b = r_b + 2'd1;
                end
            end
            ST_COP: begin
                n_pt = r_pt + IB'(1);
                if (r_c == 2'd2) begin
                    n_c = 2'd0;
                    if (r_b == 2'd2) begin
                        n_b = 2'd0;
                        if (r_a == 2'd2) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_a     = r_a + 2'd1;
                            n_state = ST_ROW;
                        end
                    end else begin
                        n_b = r_b + 2'd1;
                    end
                end else begin
                    n_c = r_c + 2'd1;
                end
            end
            ST_NEAR: begin
                n_pt = r_pt + IB'(1);
                if (r_pt == LAST_PT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a     <= 2'd0;
            r_b     <= 2'd0;
            r_c     <= 2'd0;
            r_pt    <= '0;
            r_rdv   <= 1'b0;
            r_dv    <= 1'b0;
            r_distv <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_pt    <= n_pt;
            r_rdv   <= rd_en && (r_state == ST_NEAR);
            r_dv    <= r_rdv;
            r_distv <= mul_tag.vld && (mul_tag.op == tqbe_pkg::OP_DIST);
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_near <= (s_axis_tuser == tqbe_pkg::MODE_NEAR);
            r_p    <= in_p;
            r_q    <= in_q;
            r_qc   <= in_pt;
            r_acc  <= '0;
        end

        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end

        r_di <= r_rd_idx;
        for (int k = 0; k < LN; k++) begin
            r_diff[k] <= DIFF_W'($signed(r_qc[k])) - DIFF_W'($signed(rd_data[k]));
        end

        if (mul_tag.vld) begin
            case (mul_tag.op)
                tqbe_pkg::OP_WGT: begin
                    for (int k = 0; k < LN; k++) begin
                        // The middle weight carries the factor of two.
                        if (mul_tag.idx[1:0] == 2'd1) begin
                            r_w[k][mul_tag.idx[1:0]] <= f_rnd({mul_prod[k][32:0], 1'b0});
                        end else begin
                            r_w[k][mul_tag.idx[1:0]] <= f_rnd(mul_prod[k][33:0]);
                        end
                    end
                end
                tqbe_pkg::OP_ROW: begin
                    for (int k = 0; k < LN; k++) begin
                        r_wtu[k] <= f_rnd(mul_prod[k][33:0]);
                    end
                end
                tqbe_pkg::OP_BW: begin
                    for (int k = 0; k < LN; k++) begin
                        r_wpt[mul_tag.idx[1:0]][k] <= f_rnd(mul_prod[k][33:0]);
                    end
                end
                tqbe_pkg::OP_COORD: begin
                    for (int k = 0; k < LN; k++) begin
                        r_acc[k] <= r_acc[k] + mul_prod[k][ACC_W-1:0];
                    end
                end
                tqbe_pkg::OP_DIST: begin
                    r_dist  <= DIST_W'(mul_prod[0][SQ_W-1:0])
                             + DIST_W'(mul_prod[1][SQ_W-1:0])
                             + DIST_W'(mul_prod[2][SQ_W-1:0]);
                    r_disti <= mul_tag.idx;
                end
                default: begin
                    r_dist <= r_dist;
                end
            endcase
        end

        // Strictly closer replaces the best, so the lowest index wins ties.
        if (r_distv && ((r_disti == '0) || (r_dist < r_best))) begin
            r_best <= r_dist;
            r_bidx <= r_disti;
        end

        if (out_load) begin
            for (int k = 0; k < LN; k++) begin
                r_opos[k] <= r_near ? '0 : f_finish(r_acc[k]);
            end
            r_onidx <= r_near ? r_bidx : '0;
        end
    end

    assign m_axis_tvalid = r_ovld;

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < LN; k++) begin
            m_axis_tdata[k*CB +: CB] = r_opos[k];
        end
        m_axis_tdata[LN*CB +: IB] = r_onidx;
    end

    assign pt_chk = {r_a, 3'b000} + {3'b000, r_a} + {2'b00, r_b, 1'b0}
                  + {3'b000, r_b} + {3'b000, r_c};

    `TQBE_ASSERT_IMPL(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE, pipe_empty)
    `TQBE_ASSERT_IMPL(a_cop_read_matches, i_clk, i_rst_n, r_state == ST_COP, r_rd_idx == r_pt)
    `TQBE_ASSERT_IMPL(a_cop_index_order, i_clk, i_rst_n, r_state == ST_COP, r_pt == pt_chk)
    `TQBE_ASSERT_IMPL(a_out_index_range, i_clk, i_rst_n, m_axis_tvalid, r_onidx <= LAST_PT)
    `TQBE_ASSERT_NEXT(a_eval_starts, i_clk, i_rst_n, s_acc && (s_axis_tuser == tqbe_pkg::MODE_EVAL), r_state == ST_WGT)

endmodule

### rtl/tqbe_lattice.sv
// ----------------------------------------------------------------------------
// tqbe_lattice
// Control point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tqbe_lattice (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [tqbe_pkg::IDX_BITS-1:0]      i_waddr,
    input  tqbe_pkg::t_point                   i_wdata,
    input  logic                               i_re,
    input  logic [tqbe_pkg::IDX_BITS-1:0]      i_raddr,
    output tqbe_pkg::t_point                   o_rdata
);

    tqbe_pkg::t_point r_mem [tqbe_pkg::NUM_POINTS];
    tqbe_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tqbe_mul3.sv
// ----------------------------------------------------------------------------
// tqbe_mul3
// Shared three-lane signed multiplier with registered products and tag.
// ----------------------------------------------------------------------------
module tqbe_mul3 (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  tqbe_pkg::t_mul_req                                  i_req,
    output logic [tqbe_pkg::LANES-1:0][tqbe_pkg::PROD_W-1:0]    o_prod,
    output tqbe_pkg::t_mul_tag                                  o_tag
);

    logic [tqbe_pkg::LANES-1:0][tqbe_pkg::PROD_W-1:0] r_prod;
    logic                                             r_vld;
    tqbe_pkg::t_op                                    r_op;
    logic [tqbe_pkg::IDX_BITS-1:0]                    r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= i_req.tag.op;
        r_idx <= i_req.tag.idx;
        for (int k = 0; k < tqbe_pkg::LANES; k++) begin
            r_prod[k] <= $signed(i_req.a[k]) * $signed(i_req.b[k]);
        end
    end

    assign o_prod    = r_prod;
    assign o_tag.vld = r_vld;
    assign o_tag.op  = r_op;
    assign o_tag.idx = r_idx;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for trivariate_quadratic_bezier_eval
// Loads the 3x3x3 control lattice through stream transactions, then runs
// volume evaluations and nearest-point queries. A lattice copy inside the
// bench predicts every result, and a checker compares the position and index fields.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_BITS  = tqbe_pkg::MODE_BITS;
    localparam int NUM_POINTS = tqbe_pkg::NUM_POINTS;
    localparam int LANES      = tqbe_pkg::LANES;
    localparam int COORD_BITS = tqbe_pkg::COORD_BITS;
    localparam int PARAM_BITS = tqbe_pkg::PARAM_BITS;
    localparam int IDX_BITS   = tqbe_pkg::IDX_BITS;
    localparam int IN_DATA_W  = tqbe_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = tqbe_pkg::OUT_DATA_W;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int GRID_STEP = 196608;  // 3.0 in Q8.16

    // Fields from the lowest bit up: point_index, coord_x, coord_y, coord_z,
    // param_s, param_t, param_u.
    typedef struct packed {
        logic [PARAM_BITS-1:0] param_u;
        logic [PARAM_BITS-1:0] param_t;
        logic [PARAM_BITS-1:0] param_s;
        logic [COORD_BITS-1:0] coord_z;
        logic [COORD_BITS-1:0] coord_y;
        logic [COORD_BITS-1:0] coord_x;
        logic [IDX_BITS-1:0]   point_index;
    } t_item_data;

    // Fields from the lowest bit up: pos_x, pos_y, pos_z, nearest_index, fill.
    typedef struct packed {
        logic [OUT_DATA_W-LANES*COORD_BITS-IDX_BITS-1:0] fill;
        logic [IDX_BITS-1:0]   nearest_index;
        logic [COORD_BITS-1:0] pos_z;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
    } t_answer;

    typedef logic [2:0][PARAM_BITS-1:0] t_weights;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // point_index, coord_x/y/z, param_s/t/u
    logic [MODE_BITS-1:0]  s_axis_tuser = '0;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // pos_x, pos_y, pos_z, nearest_index

    tqbe_pkg::t_point lattice [NUM_POINTS];
    t_answer awaited_answers [$];
    bit      calm = 1'b0;
    int      n_errors = 0;
    int      n_writes = 0;
    int      n_evals = 0;
    int      n_queries = 0;
    int      n_dropped = 0;
    int      idle_cycles = 0;

    trivariate_quadratic_bezier_eval dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Expected-result computation
    // ------------------------------------------------------------------------
    function automatic longint unsigned round_q16(input longint unsigned v);
        return (v + 64'd32768) >> 16;
    endfunction

    function automatic t_weights bernstein(input logic [PARAM_BITS-1:0] p);
        longint unsigned pp;
        longint unsigned qq;
        t_weights w;
        pp = (p > tqbe_pkg::ONE_Q16) ? 64'(tqbe_pkg::ONE_Q16) : 64'(p);
        qq = 64'(tqbe_pkg::ONE_Q16) - pp;
        w[0] = PARAM_BITS'(round_q16(qq * qq));
        w[1] = PARAM_BITS'(round_q16(2 * qq * pp));
        w[2] = PARAM_BITS'(round_q16(pp * pp));
        return w;
    endfunction

    function automatic t_answer eval_volume(input t_item_data d);
        t_weights ws, wt, wu;
        longint acc [LANES];
        longint w;
        longint r;
        longint maxv;
        longint minv;
        int idx;
        tqbe_pkg::t_point pos;
        t_answer ans;
        ws = bernstein(d.param_s);
        wt = bernstein(d.param_t);
        wu = bernstein(d.param_u);
        maxv = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        minv = -maxv - 1;
        for (int k = 0; k < LANES; k++) acc[k] = 0;
        for (int ti = 0; ti < 3; ti++)
            for (int ui = 0; ui < 3; ui++)
                for (int si = 0; si < 3; si++) begin
                    idx = 9 * ti + 3 * ui + si;
                    w = longint'(round_q16(round_q16(64'(wt[ti]) * 64'(wu[ui]))
                                           * 64'(ws[si])));
                    for (int k = 0; k < LANES; k++)
                        acc[k] += w * longint'($signed(lattice[idx][k]));
                end
        for (int k = 0; k < LANES; k++) begin
            // Arithmetic shift of the biased sum is a floor, as the rounding asks.
            r = (acc[k] + 32768) >>> 16;
            if (r > maxv) r = maxv;
            if (r < minv) r = minv;
            pos[k] = COORD_BITS'(r);
        end
        ans = '0;
        ans.pos_x = pos[0];
        ans.pos_y = pos[1];
        ans.pos_z = pos[2];
        return ans;
    endfunction

    function automatic t_answer find_nearest(input t_item_data d);
        tqbe_pkg::t_point probe;
        longint diff;
        longint dist2;
        longint best_dist2;
        int best_idx;
        t_answer ans;
        probe = {d.coord_z, d.coord_y, d.coord_x};
        best_dist2 = 0;
        best_idx = 0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            dist2 = 0;
            for (int k = 0; k < LANES; k++) begin
                diff = longint'($signed(probe[k])) - longint'($signed(lattice[i][k]));
                dist2 += diff * diff;
            end
            // Strictly closer only, so the lowest index keeps a tie.
            if (i == 0 || dist2 < best_dist2) begin
                best_dist2 = dist2;
                best_idx = i;
            end
        end
        ans = '0;
        ans.nearest_index = IDX_BITS'(best_idx);
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item_data rand_item();
        return t_item_data'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(9))
            0: return {1'b0, {(COORD_BITS-1){1'b1}}};
            1: return {1'b1, {(COORD_BITS-1){1'b0}}};
            2, 3: return COORD_BITS'(int'($urandom_range(1 << 20)) - (1 << 19));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [PARAM_BITS-1:0] rand_param();
        case ($urandom_range(9))
            0: return '0;
            1: return tqbe_pkg::ONE_Q16;
            2: return PARAM_BITS'($urandom_range(65537, 131071));
            default: return PARAM_BITS'($urandom_range(65536));
        endcase
    endfunction

    // Offers one item, waits for its transaction and updates the prediction.
    task automatic send_item(input logic [MODE_BITS-1:0] mode, input t_item_data d);
        while (!calm && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (mode)
            tqbe_pkg::MODE_WRITE: begin
                if (d.point_index < NUM_POINTS) begin
                    lattice[d.point_index] = {d.coord_z, d.coord_y, d.coord_x};
                    n_writes++;
                end else begin
                    n_dropped++;
                end
            end
            tqbe_pkg::MODE_EVAL: begin
                awaited_answers = {awaited_answers, eval_volume(d)};
                n_evals++;
            end
            tqbe_pkg::MODE_NEAR: begin
                awaited_answers = {awaited_answers, find_nearest(d)};
                n_queries++;
            end
            default: n_dropped++;
        endcase
    endtask

    task automatic put_point(input int idx, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] z);
        t_item_data d;
        d = rand_item();
        d.point_index = IDX_BITS'(idx);
        d.coord_x = x;
        d.coord_y = y;
        d.coord_z = z;
        send_item(tqbe_pkg::MODE_WRITE, d);
    endtask

    task automatic eval_at(input logic [PARAM_BITS-1:0] ps,
                           input logic [PARAM_BITS-1:0] pt,
                           input logic [PARAM_BITS-1:0] pu);
        t_item_data d;
        d = rand_item();
        d.param_s = ps;
        d.param_t = pt;
        d.param_u = pu;
        send_item(tqbe_pkg::MODE_EVAL, d);
    endtask

    task automatic query_near(input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y,
                              input logic [COORD_BITS-1:0] z);
        t_item_data d;
        d = rand_item();
        d.coord_x = x;
        d.coord_y = y;
        d.coord_z = z;
        send_item(tqbe_pkg::MODE_NEAR, d);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Regular grid with 3.0 spacing, centered on the origin.
    task automatic test_grid_fill();
        for (int t = 0; t < 3; t++)
            for (int u = 0; u < 3; u++)
                for (int s = 0; s < 3; s++)
                    put_point(9 * t + 3 * u + s, COORD_BITS'((s - 1) * GRID_STEP),
                              COORD_BITS'((u - 1) * GRID_STEP),
                              COORD_BITS'((t - 1) * GRID_STEP));
    endtask

    task automatic test_directed_cases();
        // Items the block must drop: write indexes past the lattice and mode 3.
        put_point(27, {1'b0, {(COORD_BITS-1){1'b1}}}, '1, '0);
        put_point(31, {1'b1, {(COORD_BITS-1){1'b0}}}, '0, '1);
        send_item(MODE_UNUSED, t_item_data'('1));
        eval_at('0, '0, '0);
        eval_at(tqbe_pkg::ONE_Q16, tqbe_pkg::ONE_Q16, tqbe_pkg::ONE_Q16);
        eval_at(PARAM_BITS'(32768), PARAM_BITS'(32768), PARAM_BITS'(32768));
        eval_at(PARAM_BITS'(16384), PARAM_BITS'(49152), tqbe_pkg::ONE_Q16);
        // Parameters above one are clamped.
        eval_at('1, PARAM_BITS'(65537), '0);
        eval_at(tqbe_pkg::ONE_Q16, '0, PARAM_BITS'(98304));
        query_near(COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(0));
        query_near({1'b0, {(COORD_BITS-1){1'b1}}}, {1'b0, {(COORD_BITS-1){1'b1}}},
                   {1'b0, {(COORD_BITS-1){1'b1}}});
        query_near({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b1, {(COORD_BITS-1){1'b0}}},
                   {1'b1, {(COORD_BITS-1){1'b0}}});
        // Equal distances to two and to eight points; the lowest index wins.
        query_near(COORD_BITS'(-98304), COORD_BITS'(-GRID_STEP), COORD_BITS'(-GRID_STEP));
        query_near(COORD_BITS'(98304), COORD_BITS'(GRID_STEP), COORD_BITS'(GRID_STEP));
        query_near(COORD_BITS'(-98304), COORD_BITS'(-98304), COORD_BITS'(-98304));
    endtask

    // Lattice pinned at the coordinate limits drives the output saturation.
    task automatic test_extreme_lattice();
        logic [COORD_BITS-1:0] hi;
        logic [COORD_BITS-1:0] lo;
        hi = {1'b0, {(COORD_BITS-1){1'b1}}};
        lo = {1'b1, {(COORD_BITS-1){1'b0}}};
        for (int i = 0; i < NUM_POINTS; i++)
            put_point(i, ($urandom_range(9) < 8) ? hi : lo,
                      ($urandom_range(9) < 8) ? hi : lo,
                      ($urandom_range(9) < 8) ? lo : hi);
        for (int i = 0; i < 12; i++) eval_at(rand_param(), rand_param(), rand_param());
        query_near(hi, hi, lo);
        // Leave a random lattice behind for the traffic that follows.
        for (int i = 0; i < NUM_POINTS; i++)
            put_point(i, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_random_traffic(input int n_items);
        int pick;
        int j;
        t_item_data d;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            j = $urandom_range(NUM_POINTS - 1);
            if (pick < 10) begin
                put_point($urandom_range(NUM_POINTS - 1), rand_coord(), rand_coord(),
                          rand_coord());
            end else if (pick < 13) begin
                // Duplicate points make ties in the nearest search.
                put_point($urandom_range(NUM_POINTS - 1), lattice[j][0], lattice[j][1],
                          lattice[j][2]);
            end else if (pick < 17) begin
                d = rand_item();
                if (pick == 16) begin
                    d.point_index = IDX_BITS'($urandom_range(NUM_POINTS, 31));
                    send_item(tqbe_pkg::MODE_WRITE, d);
                end else begin
                    send_item(MODE_UNUSED, d);
                end
            end else if (pick < 58) begin
                eval_at(rand_param(), rand_param(), rand_param());
            end else if (pick < 66) begin
                query_near(lattice[j][0], lattice[j][1], lattice[j][2]);
            end else if (pick < 86) begin
                query_near(lattice[j][0] + COORD_BITS'(int'($urandom_range(4096)) - 2048),
                           lattice[j][1] + COORD_BITS'(int'($urandom_range(4096)) - 2048),
                           lattice[j][2] + COORD_BITS'(int'($urandom_range(4096)) - 2048));
            end else begin
                query_near(rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_stream();
        calm = 1'b1;
        test_random_traffic(60);
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side, checking and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 25);

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_answers
        t_answer want;
        t_answer got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_answer'(m_axis_tdata);
            if (awaited_answers.size() == 0) begin
                $error("result transaction with no result pending: %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = awaited_answers.pop_front();
                compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
                compare_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
                compare_field("pos_z", 32'(want.pos_z), 32'(got.pos_z));
                compare_field("nearest_index", 32'(want.nearest_index),
                              32'(got.nearest_index));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
            $display("trivariate_quadratic_bezier_eval test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_grid_fill();
        test_directed_cases();
        test_extreme_lattice();
        test_random_traffic(380);
        test_steady_stream();
        s_axis_tvalid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d control point writes, %0d volume evaluations and %0d nearest",
                 n_writes, n_evals, n_queries);
        $display("queries, plus %0d items the block had to drop.", n_dropped);
        if (n_errors == 0) begin
            $display("trivariate_quadratic_bezier_eval test passed");
        end else begin
            $display("trivariate_quadratic_bezier_eval test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tqbe_pkg.sv
rtl/tqbe_lattice.sv
rtl/tqbe_mul3.sv
rtl/trivariate_quadratic_bezier_eval.sv
sim/tb.sv
